>>> hdl/gated_angle_kalman_filter_unit_macros.svh
// Assertion macros used by the checker file of the gated angle Kalman filter
`ifndef GATED_ANGLE_KALMAN_FILTER_UNIT_MACROS_SVH
`define GATED_ANGLE_KALMAN_FILTER_UNIT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle
`define GAKF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gakf next-cycle check failed");

// Antecedent implies a delayed consequent
`define GAKF_ASSERT_LATER(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("gakf two-cycle check failed");

`endif

>>> hdl/gakf_pkg.sv
// Package with types, constants and register codes of the gated angle Kalman filter
package gakf_pkg;

	localparam int WIN_DEPTH = 5;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int DIV_STEPS = 25;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] REG_TRACK_THRESHOLD    = 3'd0;
	localparam logic [2:0] REG_CORRELATION_MARGIN = 3'd1;
	localparam logic [2:0] REG_OUTLIER_LIMIT      = 3'd2;
	localparam logic [2:0] REG_PROCESS_NOISE      = 3'd3;
	localparam logic [2:0] REG_MEASUREMENT_NOISE  = 3'd4;

	localparam logic [15:0] THRESHOLD_RST = 16'd0;
	localparam logic [15:0] MARGIN_RST    = 16'd20;
	localparam logic [30:0] LIMIT_RST     = 31'd655360;
	localparam logic [23:0] PNOISE_RST    = 24'd1678;
	localparam logic [23:0] MNOISE_RST    = 24'd1677722;
	localparam logic [31:0] VARIANCE_RST  = 32'd1677722;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH,
		ST_ACC,
		ST_TEST,
		ST_PREP,
		ST_DIVK,
		ST_MULK,
		ST_UPD,
		ST_MULP,
		ST_LOADP,
		ST_DIVP,
		ST_DONE
	} state_t;

endpackage

>>> hdl/gated_angle_kalman_filter_unit.sv
// Top level of the gated angle Kalman filter: sequencer, window, shared divider and multiplier
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_stall, platform_angle, detected_angle,  | into block
//          | correlation                                          |
//  out     | out_valid, out_stall, filtered_angle                 | out of block
//  cfg     | cfg_we, cfg_index, cfg_data                          | into block
//
// Each item runs through push, a window sum of one entry per cycle, test, setup, two
// 25-step restoring divisions (gain and new variance) on one shared divider and two
// products on one shared multiplier. A zero gain divisor skips the divisions and the
// products. in_stall stays high while an item is in work. The result sits in an
// output register; the next item may be taken while it waits.
// Reset clears the window count, estimate, variance and registers to their defaults.
module gated_angle_kalman_filter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [30:0]  platform_angle,
	input  logic signed [30:0]  detected_angle,
	input  logic        [15:0]  correlation,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  filtered_angle,
	input  logic                cfg_we,
	input  logic        [2:0]   cfg_index,
	input  logic        [30:0]  cfg_data
);

	localparam int CW = gakf_pkg::CNT_W;
	localparam int IW = gakf_pkg::IDX_W;
	localparam int TW = 32 + CW;
	localparam int DW = 32 + CW + 2;
	localparam int SW = gakf_pkg::STEP_W;

	gakf_pkg::state_t state_q, state_d;

	logic        [15:0] thr_q, margin_q;
	logic        [30:0] limit_q;
	logic        [23:0] pnoise_q, mnoise_q;

	logic signed [31:0] win_q [gakf_pkg::WIN_DEPTH];
	logic        [CW-1:0] cnt_q, idx_q;
	logic signed [TW-1:0] total_q;
	logic signed [31:0] est_q, sum_q, z_q;
	logic        [31:0] var_q, pp_q;
	logic        [15:0] corr_q;
	logic        [32:0] d_q, mag_q, rem_q;
	logic               neg_q;
	logic        [24:0] shf_q, k_q;
	logic        [SW-1:0] step_q;
	logic        [57:0] prod_q;
	logic               out_valid_q;
	logic signed [31:0] out_q;

	logic signed [16:0] gate;
	logic signed [16:0] corr_s;
	logic signed [DW-1:0] ns, dev, dev_abs;
	logic        [DW-1:0] nl;
	logic               outlier;
	logic        [32:0] pp_sum;
	logic        [32:0] d_next;
	logic        [56:0] numk, nump;
	logic        [33:0] rem_sh;
	logic        [33:0] rem_sub;
	logic        [32:0] mul_a;
	logic        [24:0] mul_b;
	logic        [34:0] corr_amt;
	logic signed [35:0] x_full;
	logic signed [31:0] x_clamp;
	logic signed [32:0] innov;

	// Gate and outlier test
	always_comb begin
		gate    = $signed({1'b0, thr_q}) - $signed({1'b0, margin_q});
		corr_s  = $signed({1'b0, corr_q});
		ns      = $signed({1'b0, cnt_q}) * sum_q;
		dev     = ns - DW'(total_q);
		dev_abs = dev[DW-1] ? -dev : dev;
		nl      = DW'(cnt_q) * DW'(limit_q);
		outlier = (cnt_q != '0) && (dev_abs > $signed(nl));
	end

	// Predicted variance, divisor and dividends
	always_comb begin
		pp_sum = {1'b0, var_q} + 33'(pnoise_q);
		d_next = {1'b0, pp_q} + 33'(mnoise_q);
		numk   = {1'b0, pp_q, 24'd0} + 57'(d_next[32:1]);
		nump   = prod_q[56:0] + 57'(d_q[32:1]);
		innov  = 33'(z_q) - 33'(est_q);
	end

	// Divider step and shared multiplier operands
	always_comb begin
		rem_sh  = {rem_q, shf_q[24]};
		rem_sub = rem_sh - {1'b0, d_q};
		mul_a   = (state_q == gakf_pkg::ST_MULK) ? mag_q : {1'b0, pp_q};
		mul_b   = (state_q == gakf_pkg::ST_MULK) ? k_q : {1'b0, mnoise_q};
	end

	// Estimate correction with clamp
	always_comb begin
		corr_amt = 35'((prod_q + 58'(1 << 23)) >> 24);
		x_full   = neg_q ? (36'(est_q) - $signed({1'b0, corr_amt}))
		                 : (36'(est_q) + $signed({1'b0, corr_amt}));
		if (x_full > 36'sd2147483647)
			x_clamp = 32'sh7FFFFFFF;
		else if (x_full < -36'sd2147483648)
			x_clamp = 32'sh80000000;
		else
			x_clamp = x_full[31:0];
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			gakf_pkg::ST_IDLE:  if (in_valid) state_d = gakf_pkg::ST_PUSH;
			gakf_pkg::ST_PUSH:  state_d = gakf_pkg::ST_ACC;
			gakf_pkg::ST_ACC:   if (idx_q == cnt_q) state_d = gakf_pkg::ST_TEST;
			gakf_pkg::ST_TEST:  state_d = gakf_pkg::ST_PREP;
			gakf_pkg::ST_PREP:  state_d = (d_next == '0) ? gakf_pkg::ST_DONE
			                                             : gakf_pkg::ST_DIVK;
			gakf_pkg::ST_DIVK:  if (step_q == SW'(1)) state_d = gakf_pkg::ST_MULK;
			gakf_pkg::ST_MULK:  state_d = gakf_pkg::ST_UPD;
			gakf_pkg::ST_UPD:   state_d = gakf_pkg::ST_MULP;
			gakf_pkg::ST_MULP:  state_d = gakf_pkg::ST_LOADP;
			gakf_pkg::ST_LOADP: state_d = gakf_pkg::ST_DIVP;
			gakf_pkg::ST_DIVP:  if (step_q == SW'(1)) state_d = gakf_pkg::ST_DONE;
			gakf_pkg::ST_DONE:  if (!out_valid_q || !out_stall) state_d = gakf_pkg::ST_IDLE;
			default:            state_d = gakf_pkg::ST_IDLE;
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gakf_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= gakf_pkg::THRESHOLD_RST;
			margin_q <= gakf_pkg::MARGIN_RST;
			limit_q  <= gakf_pkg::LIMIT_RST;
			pnoise_q <= gakf_pkg::PNOISE_RST;
			mnoise_q <= gakf_pkg::MNOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gakf_pkg::REG_TRACK_THRESHOLD:    thr_q    <= cfg_data[15:0];
				gakf_pkg::REG_CORRELATION_MARGIN: margin_q <= cfg_data[15:0];
				gakf_pkg::REG_OUTLIER_LIMIT:      limit_q  <= cfg_data;
				gakf_pkg::REG_PROCESS_NOISE:      pnoise_q <= cfg_data[23:0];
				gakf_pkg::REG_MEASUREMENT_NOISE:  mnoise_q <= cfg_data[23:0];
				default:                          ;
			endcase
		end
	end

	// Filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			est_q       <= '0;
			var_q       <= gakf_pkg::VARIANCE_RST;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result when leaving DONE, drop it once taken
			if (state_q == gakf_pkg::ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				gakf_pkg::ST_PUSH: begin
					if (corr_s < gate && cnt_q < CW'(gakf_pkg::WIN_DEPTH))
						cnt_q <= cnt_q + CW'(1);
				end
				gakf_pkg::ST_PREP: begin
					if (d_next == '0)
						var_q <= '0;
				end
				gakf_pkg::ST_UPD:  est_q <= x_clamp;
				gakf_pkg::ST_DIVP: begin
					if (step_q == SW'(1))
						var_q <= {7'd0, shf_q[23:0], ~rem_sub[33]};
				end
				default: ;
			endcase
		end
	end

	// Work registers: window, accumulator, divider, multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			gakf_pkg::ST_IDLE: begin
				sum_q  <= 32'(platform_angle) + 32'(detected_angle);
				corr_q <= correlation;
			end
			gakf_pkg::ST_PUSH: begin
				// push, dropping the oldest sum when full
				if (corr_s < gate) begin
					if (cnt_q < CW'(gakf_pkg::WIN_DEPTH)) begin
						win_q[cnt_q[IW-1:0]] <= sum_q;
					end else begin
						for (int i = 0; i < gakf_pkg::WIN_DEPTH - 1; i++)
							win_q[i] <= win_q[i+1];
						win_q[gakf_pkg::WIN_DEPTH-1] <= sum_q;
					end
				end
				idx_q   <= '0;
				total_q <= '0;
			end
			gakf_pkg::ST_ACC: begin
				if (idx_q != cnt_q) begin
					total_q <= total_q + TW'(win_q[idx_q[IW-1:0]]);
					idx_q   <= idx_q + CW'(1);
				end
			end
			gakf_pkg::ST_TEST: begin
				z_q  <= (outlier || corr_s > gate) ? est_q : sum_q;
				pp_q <= pp_sum[32] ? 32'hFFFFFFFF : pp_sum[31:0];
			end
			gakf_pkg::ST_PREP: begin
				d_q    <= d_next;
				rem_q  <= {1'b0, numk[56:25]};
				shf_q  <= numk[24:0];
				step_q <= SW'(gakf_pkg::DIV_STEPS);
				neg_q  <= innov[32];
				mag_q  <= innov[32] ? 33'(-innov) : 33'(innov);
			end
			gakf_pkg::ST_DIVK, gakf_pkg::ST_DIVP: begin
				// one quotient bit per cycle, shifted in behind the dividend
				rem_q  <= rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0];
				shf_q  <= {shf_q[23:0], ~rem_sub[33]};
				step_q <= step_q - SW'(1);
				if (state_q == gakf_pkg::ST_DIVK && step_q == SW'(1))
					k_q <= {shf_q[23:0], ~rem_sub[33]};
			end
			gakf_pkg::ST_MULK, gakf_pkg::ST_MULP: prod_q <= mul_a * mul_b;
			gakf_pkg::ST_LOADP: begin
				rem_q  <= {1'b0, nump[56:25]};
				shf_q  <= nump[24:0];
				step_q <= SW'(gakf_pkg::DIV_STEPS);
			end
			gakf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					out_q <= est_q;
			end
			default: ;
		endcase
	end

	assign in_stall       = (state_q != gakf_pkg::ST_IDLE);
	assign out_valid      = out_valid_q;
	assign filtered_angle = out_q;

endmodule

>>> hdl/gakf_checker.sv
// Port checker of the gated angle Kalman filter and its bind to the top level
`include "gated_angle_kalman_filter_unit_macros.svh"

module gakf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] filtered_angle
);

	`GAKF_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)
	`GAKF_ASSERT_LATER(busy_two_after_accept, in_valid && !in_stall, in_stall)
	`GAKF_ASSERT_NEXT(result_held, out_valid && out_stall, out_valid && $stable(filtered_angle))

endmodule

bind gated_angle_kalman_filter_unit gakf_checker u_gakf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.filtered_angle (filtered_angle)
);
